// ===== design/ffpa_pkg.sv =====
// shared types and constants for the first-fit pool allocator
`default_nettype none
package ffpa_pkg;

	localparam int POOL_BYTES_DEF   = 8192;
	localparam int HEADER_BYTES_DEF = 40;
	localparam int MAX_BLOCKS_DEF   = 256;
	localparam int SPLIT_MIN        = 16;
	localparam int ALIGN_BYTES      = 8;
	localparam int FIELD_W          = 13;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_OOM     = 2'd2,
		ST_BAD_REL = 2'd3
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic [FIELD_W-1:0] request_bytes;
		logic [FIELD_W-1:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] payload_offset;
		logic [FIELD_W-1:0] granted_bytes;
		logic [FIELD_W-1:0] free_total;
		logic [FIELD_W-1:0] largest_free;
	} rsp_t;

endpackage
`default_nettype wire

// ===== design/first_fit_pool_allocator.sv =====
// Usage: first-fit pool allocator with coalescing on free.
// in_valid/in_ready take one request word {req_type, request_bytes, release_offset};
// out_valid/out_ready hand back one result word per request.
// The block table lives in a ring of MAX_BLOCKS cells. Each request rotates the
// ring once through the controller, which sees one entry per cycle at the head
// cell and writes the edited entry stream into the tail cell, splitting,
// freeing and merging on the fly and summing the free space as it goes.
// One request is in work at a time: a new request is taken only after the pass
// of the previous one has ended and the controller is back in idle.
// in_ready is high while no request is in work; a new request may be accepted
// while the previous result still waits in the output register.
// If a previous result still waits in the output register when a pass ends, the
// ring holds its last step until the output register frees up.
// Reset (arst_n low) returns the table to one free block covering the pool,
// with the block count at one; no clearing pass is needed.
`default_nettype none
module first_fit_pool_allocator #(
	parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
	parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffpa_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ffpa_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ffpa_pkg::rsp_t      out_data
);
	import ffpa_pkg::*;

	localparam int AW0 = $clog2(POOL_BYTES) + 1;
	localparam int DW  = (AW0 > FIELD_W + 1) ? AW0 : FIELD_W + 1;
	localparam int EW  = 2 + 2 * DW;
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int NW  = $clog2(MAX_BLOCKS + 2);
	localparam logic [DW-1:0] HB   = DW'(HEADER_BYTES);
	localparam logic [DW-1:0] SMIN = DW'(SPLIT_MIN);
	localparam logic [NW-1:0] LAST = NW'(MAX_BLOCKS);
	localparam logic [NW-1:0] PENU = NW'(MAX_BLOCKS - 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);
	localparam logic [EW-1:0] RST0 = {1'b1, 1'b1, {DW{1'b0}}, DW'(POOL_BYTES - HEADER_BYTES)};

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t         state_q;
	logic [NW-1:0]  cnt_q;
	logic [CW-1:0]  count_q, count_n;
	logic           op_q, zero_q;
	logic [DW-1:0]  aligned_q, off_q;
	logic           found_q;
	logic [1:0]     sel_q;
	logic [1:0]     fn_q;
	logic [EW-1:0]  e0_q, e1_q;
	logic [DW-1:0]  tot_q, lg_q, tot_n, lg_n;
	logic [1:0]     st_q;
	logic [DW-1:0]  pay_q, gr_q;
	logic           out_valid_q;
	rsp_t           out_q;

	logic [EW-1:0]  cq [MAX_BLOCKS];
	logic [EW-1:0]  wr;
	logic           en, rd, last, done_ok;

	genvar g;
	generate
		for (g = 0; g < MAX_BLOCKS; g++) begin : g_ring
			if (g == MAX_BLOCKS - 1) begin : g_tail
				ffpa_cell #(.EW(EW), .RST('0)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(en), .d(wr), .q(cq[g])
				);
			end else if (g == 0) begin : g_head
				ffpa_cell #(.EW(EW), .RST(RST0)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(en), .d(cq[g+1]), .q(cq[g])
				);
			end else begin : g_mid
				ffpa_cell #(.EW(EW), .RST('0)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(en), .d(cq[g+1]), .q(cq[g])
				);
			end
		end
	endgenerate

	// current entry, taken further down the ring once merged entries were dropped
	logic [EW-1:0] cur;
	always_comb begin
		case (sel_q)
			2'd1: cur = cq[1];
			// on the last read the third cell already holds rewritten data
			2'd2: cur = (cnt_q == PENU) ? '0 : cq[2];
			default: cur = cq[0];
		endcase
	end

	// current entry and its successor
	logic          xv, xf, yv, yf;
	logic [DW-1:0] xs, xz, yz;
	assign xv = cur[EW-1];
	assign xf = cur[EW-2];
	assign xs = cur[2*DW-1:DW];
	assign xz = cur[DW-1:0];
	assign yv = cq[1][EW-1];
	assign yf = cq[1][EW-2];
	assign yz = cq[1][DW-1:0];

	assign last    = (cnt_q == LAST);
	assign rd      = (state_q == S_RUN) && !last;
	assign done_ok = !out_valid_q || out_ready;
	assign en      = (state_q == S_RUN) && (!last || done_ok);

	logic          hit_a, hit_f, split, yok, pmerge;
	logic [1:0]    pc;
	logic [EW-1:0] p0, p1;
	logic [DW-1:0] s_free;

	always_comb begin
		hit_a  = rd && (op_q == REQ_ALLOC) && !zero_q && !found_q && xv && xf
			&& (xz >= aligned_q);
		split  = (xz > aligned_q + HB + SMIN) && (count_q < CMAX);
		hit_f  = rd && (op_q == REQ_FREE) && !found_q && xv && !xf
			&& (xs + HB == off_q);
		yok    = (cnt_q < PENU) && yv && yf;
		s_free = xz + (yok ? yz + HB : '0);
		pmerge = hit_f && (fn_q != 2'd0) && e0_q[EW-1] && e0_q[EW-2];
		p0 = cur;
		p1 = '0;
		pc = rd ? 2'd1 : 2'd0;
		if (hit_a) begin
			p0 = {1'b1, 1'b0, xs, split ? aligned_q : xz};
			if (split) begin
				p1 = {1'b1, 1'b1, xs + HB + aligned_q, xz - aligned_q - HB};
				pc = 2'd2;
			end
		end
		if (hit_f) begin
			if (pmerge) begin
				// freed block folds into the previous one, pull the following entry forward
				p0 = yok ? cq[2] : cq[1];
			end else begin
				p0 = {1'b1, 1'b1, xs, s_free};
			end
		end
		// word written into the tail cell this cycle
		if (fn_q == 2'd0) begin
			wr = '0;
		end else if (pmerge) begin
			wr = {e0_q[EW-1:DW], e0_q[DW-1:0] + s_free + HB};
		end else begin
			wr = e0_q;
		end
		count_n = count_q;
		if (hit_a && split) begin
			count_n = count_q + CW'(1);
		end
		if (hit_f) begin
			count_n = count_q - CW'(yok) - CW'(pmerge);
		end
		tot_n = tot_q;
		lg_n  = lg_q;
		if ((cnt_q != '0) && wr[EW-1] && wr[EW-2]) begin
			tot_n = tot_q + wr[DW-1:0];
			if (wr[DW-1:0] > lg_q) begin
				lg_n = wr[DW-1:0];
			end
		end
	end

	logic [1:0] fin_st;
	always_comb begin
		fin_st = st_q;
		if (op_q == REQ_ALLOC && !zero_q && !found_q) begin
			fin_st = ST_OOM;
		end else if (op_q == REQ_FREE && !found_q) begin
			fin_st = ST_BAD_REL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= CW'(1);
			found_q     <= 1'b0;
			sel_q       <= '0;
			fn_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RUN && last && en) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						cnt_q   <= '0;
						found_q <= 1'b0;
						sel_q   <= '0;
						fn_q    <= '0;
					end
				end
				S_RUN: begin
					if (en) begin
						cnt_q   <= cnt_q + NW'(1);
						count_q <= count_n;
						if (hit_a || hit_f) begin
							found_q <= 1'b1;
						end
						if (hit_f) begin
							sel_q <= 2'(yok) + 2'(pmerge);
						end
						if (fn_q == 2'd0 || fn_q == 2'd1) begin
							fn_q <= pc;
						end else begin
							fn_q <= 2'd1 + 2'(pc != 2'd0);
						end
						if (last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q      <= in_data.req_type;
			zero_q    <= (in_data.request_bytes == '0);
			aligned_q <= (DW'(in_data.request_bytes) + DW'(ALIGN_BYTES - 1))
				& ~DW'(ALIGN_BYTES - 1);
			off_q     <= DW'(in_data.release_offset);
			st_q      <= (in_data.req_type == REQ_ALLOC && in_data.request_bytes == '0)
				? ST_ZERO : ST_OK;
			pay_q     <= '0;
			gr_q      <= '0;
			tot_q     <= '0;
			lg_q      <= '0;
		end else if (en) begin
			tot_q <= tot_n;
			lg_q  <= lg_n;
			if (hit_a) begin
				pay_q <= xs + HB;
				gr_q  <= aligned_q;
			end
			if (hit_f) begin
				gr_q <= xz;
			end
			if (fn_q == 2'd0 || fn_q == 2'd1) begin
				e0_q <= p0;
				e1_q <= p1;
			end else begin
				e0_q <= e1_q;
				e1_q <= p0;
			end
			if (last) begin
				out_q.status         <= fin_st;
				out_q.payload_offset <= pay_q[FIELD_W-1:0];
				out_q.granted_bytes  <= gr_q[FIELD_W-1:0];
				out_q.free_total     <= tot_n[FIELD_W-1:0];
				out_q.largest_free   <= lg_n[FIELD_W-1:0];
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CMAX))
		else $error("block count out of range");
	a_fifo_depth: assert property (@(posedge clk) disable iff (!arst_n)
		fn_q != 2'd3)
		else $error("edit buffer overflow");
	a_pass_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && last && en |=> out_valid_q && (state_q == S_IDLE))
		else $error("pass end did not post a result");
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && (state_q == S_RUN) |-> !hit_a && !hit_f)
		else $error("second match in one pass");

endmodule
`default_nettype wire

// ===== design/ffpa_cell.sv =====
// one block table slot of the circulating chain
`default_nettype none
module ffpa_cell #(
	parameter int          EW  = 36,
	parameter logic [EW-1:0] RST = '0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire logic [EW-1:0] d,
	output logic      [EW-1:0] q
);

	logic [EW-1:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= RST;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire
